// ----- rtl/core/sbpe_pkg.sv -----
// Shared constants for the Stern-Brocot path encoder.
// No dependencies.
package sbpe_pkg;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int MAX_TERMS_DEF   = 48;
   localparam int OUT_WIDTH       = 32;
endpackage

// ----- rtl/core/sbpe_divider.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sbpe_pkg.
module sbpe_divider import sbpe_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [VALUE_WIDTH-1:0] divisor,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] quotient,
   output logic [VALUE_WIDTH-1:0] remainder
);
   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] quo_ff, quo_in, rem_ff, rem_in, dsr_ff, dsr_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   run_ff, run_in, done_ff, done_in;
   logic [VALUE_WIDTH:0]   shifted, diff;

   always_comb begin
      shifted  = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      diff     = shifted - {1'b0, dsr_ff};
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         count_in = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         if (!diff[VALUE_WIDTH]) begin
            rem_in = diff[VALUE_WIDTH-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[VALUE_WIDTH-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CW'(VALUE_WIDTH - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      count_ff <= count_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

// ----- rtl/core/stern_brocot_path_encoder.sv -----
// Stern-Brocot path encoder: one fraction in, one word per run out.
// Depends on sbpe_pkg and sbpe_divider.
//
//  channel | direction | ports
//  req     | in        | req_valid, req_ready, req_numerator, req_denominator
//  rsp     | out       | rsp_valid, rsp_ready, rsp_direction .. rsp_last
//
// Per run: the serial divider (start, VALUE_WIDTH quotient bits, done), then one
// shift-add step per significant bit of the run length plus a final step in the
// multiplier, then the output word. A fraction takes up to MAX_TERMS runs; a zero
// operand skips the divider and goes straight to the output.
// Reset clears control only; bounds are reloaded with each fraction.
// A stalled rsp holds the engine; req is taken only when the engine is idle.
module stern_brocot_path_encoder import sbpe_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int MAX_TERMS   = MAX_TERMS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_numerator,
   input  logic [VALUE_WIDTH-1:0] req_denominator,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_direction,
   output logic [OUT_WIDTH-1:0]   rsp_run_length,
   output logic [OUT_WIDTH-1:0]   rsp_lower_num,
   output logic [OUT_WIDTH-1:0]   rsp_lower_den,
   output logic [OUT_WIDTH-1:0]   rsp_upper_num,
   output logic [OUT_WIDTH-1:0]   rsp_upper_den,
   output logic                   rsp_invalid,
   output logic                   rsp_last
);
   localparam int CW = $clog2(MAX_TERMS + 1);

   typedef enum logic [1:0] {S_IDLE, S_DIVIDE, S_MULT, S_EMIT} state_type;

   state_type              state_ff;
   logic [VALUE_WIDTH-1:0] dvd_ff, dsr_ff;
   logic [VALUE_WIDTH-1:0] lo_num_ff, lo_den_ff, hi_num_ff, hi_den_ff;
   logic [VALUE_WIDTH-1:0] k_ff, kshift_ff, m_num_ff, m_den_ff;
   logic [CW-1:0]          cnt_ff;
   logic                   fin_ff, dir_ff, invalid_ff, last_ff, start_ff;
   logic                   start_in;

   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_q, div_r;

   sbpe_divider #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .dividend  (dvd_ff),
      .divisor   (dsr_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // kick the divider on a valid fraction or after a non-final word leaves
   assign start_in = (state_ff == S_IDLE && req_valid &&
                      req_numerator != '0 && req_denominator != '0) ||
                     (state_ff == S_EMIT && rsp_ready && !last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b0;
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         start_ff <= start_in;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  lo_num_ff  <= '0;
                  hi_den_ff  <= '0;
                  cnt_ff     <= '0;
                  dir_ff     <= 1'b0;
                  k_ff       <= '0;
                  if (req_numerator == '0 || req_denominator == '0) begin
                     lo_den_ff  <= '0;
                     hi_num_ff  <= '0;
                     invalid_ff <= 1'b1;
                     last_ff    <= 1'b1;
                     state_ff   <= S_EMIT;
                  end else begin
                     lo_den_ff  <= VALUE_WIDTH'(1);
                     hi_num_ff  <= VALUE_WIDTH'(1);
                     invalid_ff <= 1'b0;
                     last_ff    <= 1'b0;
                     dvd_ff     <= req_numerator;
                     dsr_ff     <= req_denominator;
                     state_ff   <= S_DIVIDE;
                  end
               end
            end
            S_DIVIDE: begin
               if (div_done) begin
                  // exact division: last term is one less
                  fin_ff    <= (div_r == '0);
                  k_ff      <= (div_r == '0) ? div_q - 1'b1 : div_q;
                  kshift_ff <= (div_r == '0) ? div_q - 1'b1 : div_q;
                  dir_ff    <= cnt_ff[0];
                  m_num_ff  <= cnt_ff[0] ? lo_num_ff : hi_num_ff;
                  m_den_ff  <= cnt_ff[0] ? lo_den_ff : hi_den_ff;
                  dvd_ff    <= dsr_ff;
                  dsr_ff    <= div_r;
                  state_ff  <= S_MULT;
               end
            end
            S_MULT: begin
               if (kshift_ff == '0) begin
                  last_ff  <= fin_ff ||
                              ((CW + 1)'(cnt_ff) + 1'b1 >= (CW + 1)'(MAX_TERMS));
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= S_EMIT;
               end else begin
                  if (kshift_ff[0]) begin
                     if (dir_ff) begin
                        hi_num_ff <= hi_num_ff + m_num_ff;
                        hi_den_ff <= hi_den_ff + m_den_ff;
                     end else begin
                        lo_num_ff <= lo_num_ff + m_num_ff;
                        lo_den_ff <= lo_den_ff + m_den_ff;
                     end
                  end
                  m_num_ff  <= m_num_ff << 1;
                  m_den_ff  <= m_den_ff << 1;
                  kshift_ff <= kshift_ff >> 1;
               end
            end
            S_EMIT: begin
               if (rsp_ready) begin
                  if (last_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_DIVIDE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = (state_ff == S_EMIT);
   assign rsp_direction  = dir_ff;
   assign rsp_run_length = OUT_WIDTH'(k_ff);
   assign rsp_lower_num  = OUT_WIDTH'(lo_num_ff);
   assign rsp_lower_den  = OUT_WIDTH'(lo_den_ff);
   assign rsp_upper_num  = OUT_WIDTH'(hi_num_ff);
   assign rsp_upper_den  = OUT_WIDTH'(hi_den_ff);
   assign rsp_invalid    = invalid_ff;
   assign rsp_last       = last_ff;

   a_invalid_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> rsp_last) else $error("invalid word not last");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (CW + 1)'(cnt_ff) <= (CW + 1)'(MAX_TERMS)) else $error("term count overrun");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> dsr_ff != '0) else $error("division by zero started");
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIVIDE) else $error("divider done out of step");
endmodule
